[rtl/mfd_pkg.sv]
// ----------------------------------------------------------------------------
// Movable feast dates package
// Field widths, month numbers and the records shared by the core and its
// date mapping stage.
// ----------------------------------------------------------------------------
package mfd_pkg;

    // Width of the year field and of the shared divider's dividend.
    localparam int YEAR_W    = 14;
    // Divisor width: the largest constant divisor is 451.
    localparam int DIVISOR_W = 9;
    // Reciprocals of the constant divisors are scaled by 2^RECIP_SHIFT; the
    // largest one, for a divisor of 3, needs RECIP_W bits.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 23;

    localparam int MONTH_W = 3;
    localparam int DAY_W   = 5;

    // Month numbers, counting from 1 = January.
    localparam logic [MONTH_W-1:0] MONTH_FEB = 3'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 3'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 3'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 3'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 3'd6;

    // Easter Sunday as found by the computus.
    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } easter_t;

    // Month and day of all five feasts.
    typedef struct packed {
        logic [1:0]         carnival_month;
        logic [DAY_W-1:0]   carnival_day;
        logic [MONTH_W-1:0] good_friday_month;
        logic [DAY_W-1:0]   good_friday_day;
        logic [MONTH_W-1:0] paschal_month;
        logic [DAY_W-1:0]   paschal_day;
        logic [MONTH_W-1:0] ascension_month;
        logic [DAY_W-1:0]   ascension_day;
        logic [MONTH_W-1:0] whitsun_month;
        logic [DAY_W-1:0]   whitsun_day;
    } feast_dates_t;

endpackage

[rtl/mfd_divider.sv]
// ----------------------------------------------------------------------------
// Shared constant divider
// Divides a 14-bit value by a constant divisor through its rounded-up
// reciprocal: the operands are registered at start, then the quotient and
// then the remainder, and done pulses when both are final.
// ----------------------------------------------------------------------------
module mfd_divider
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mfd_pkg::YEAR_W-1:0]      dividend,
    input  logic [mfd_pkg::DIVISOR_W-1:0]   divisor,
    input  logic [mfd_pkg::RECIP_W-1:0]     recip,
    output logic                            done,
    output logic [mfd_pkg::YEAR_W-1:0]      quot,
    output logic [mfd_pkg::DIVISOR_W-1:0]   rem
);

    localparam int YW = mfd_pkg::YEAR_W;
    localparam int DW = mfd_pkg::DIVISOR_W;
    localparam int RW = mfd_pkg::RECIP_W;
    localparam int PW = YW + RW;
    localparam int BW = YW + DW;

    logic            busy_reg;
    logic            phase_reg;
    logic            done_reg;
    logic [YW-1:0]   dvd_reg;
    logic [YW-1:0]   quot_reg;
    logic [DW-1:0]   dsr_reg;
    logic [DW-1:0]   rem_reg;
    logic [RW-1:0]   recip_reg;

    logic [PW-1:0]   scaled;
    logic [BW-1:0]   back;
    logic [YW-1:0]   diff;

    // Quotient: the dividend times the reciprocal, scaled back down. The
    // rounding error of each reciprocal stays below 2^10, so the result is
    // exact for every 14-bit dividend.
    assign scaled = PW'(dvd_reg) * PW'(recip_reg);

    // Remainder: what is left after taking quotient times divisor away.
    assign back = BW'(quot_reg) * BW'(dsr_reg);
    assign diff = dvd_reg - back[YW-1:0];

    // Control: a quotient phase, a remainder phase and a completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg & phase_reg & ~start;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                busy_reg  <= ~phase_reg;
                phase_reg <= ~phase_reg;
            end
        end
    end

    // Datapath: operands, then quotient, then remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg   <= dividend;
            dsr_reg   <= divisor;
            recip_reg <= recip;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                quot_reg <= YW'(scaled >> mfd_pkg::RECIP_SHIFT);
            end
            else
            begin
                rem_reg <= diff[DW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

[rtl/mfd_dates.sv]
// ----------------------------------------------------------------------------
// Feast date mapping
// Places carnival Sunday, Good Friday, Ascension and Whitsunday relative to
// Easter and registers all five dates as the result transaction.
// ----------------------------------------------------------------------------
module mfd_dates
(
    input  logic                  clk,
    input  logic                  load,
    input  logic                  leap,
    input  mfd_pkg::easter_t      easter,
    output mfd_pkg::feast_dates_t dates
);

    // Days counted from March 1 (0 based); Easter falls on 21..55.
    logic [5:0]            x;
    mfd_pkg::feast_dates_t dates_next;
    mfd_pkg::feast_dates_t dates_reg;

    assign x = (easter.month == mfd_pkg::MONTH_APR) ? (6'(easter.day) + 6'd30)
                                                    : (6'(easter.day) - 6'd1);

    // Each feast crosses at most one or two month ends from Easter.
    always_comb
    begin
        dates_next = '0;

        // Carnival Sunday, 49 days before Easter: late February or early March.
        if (x >= 6'd49)
        begin
            dates_next.carnival_month = 2'(mfd_pkg::MONTH_MAR);
            dates_next.carnival_day   = 5'(x - 6'd48);
        end
        else
        begin
            dates_next.carnival_month = 2'(mfd_pkg::MONTH_FEB);
            dates_next.carnival_day   = leap ? 5'(x - 6'd19) : 5'(x - 6'd20);
        end

        // Good Friday, two days before Easter.
        if (x < 6'd33)
        begin
            dates_next.good_friday_month = mfd_pkg::MONTH_MAR;
            dates_next.good_friday_day   = 5'(x - 6'd1);
        end
        else
        begin
            dates_next.good_friday_month = mfd_pkg::MONTH_APR;
            dates_next.good_friday_day   = 5'(x - 6'd32);
        end

        dates_next.paschal_month = easter.month;
        dates_next.paschal_day   = easter.day;

        // Ascension day, 39 days after Easter.
        if (x < 6'd22)
        begin
            dates_next.ascension_month = mfd_pkg::MONTH_APR;
            dates_next.ascension_day   = 5'(x + 6'd9);
        end
        else if (x < 6'd53)
        begin
            dates_next.ascension_month = mfd_pkg::MONTH_MAY;
            dates_next.ascension_day   = 5'(x - 6'd21);
        end
        else
        begin
            dates_next.ascension_month = mfd_pkg::MONTH_JUN;
            dates_next.ascension_day   = 5'(x - 6'd52);
        end

        // Whitsunday, 49 days after Easter.
        if (x < 6'd43)
        begin
            dates_next.whitsun_month = mfd_pkg::MONTH_MAY;
            dates_next.whitsun_day   = 5'(x - 6'd11);
        end
        else
        begin
            dates_next.whitsun_month = mfd_pkg::MONTH_JUN;
            dates_next.whitsun_day   = 5'(x - 6'd42);
        end
    end

    // Result register, loaded once per year.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dates_reg <= dates_next;
        end
    end

    assign dates = dates_reg;

endmodule

[rtl/movable_feast_dates_core.sv]
// ----------------------------------------------------------------------------
// Movable feast dates core
// Each accepted year runs through eight constant divisions, one after another
// on a single shared reciprocal divider (issue, quotient, remainder, capture
// for each), then through a mapping step that raises m_tvalid.
// No new year is taken until the last is through: s_tready is low while a year
// is being worked on, and a finished result may wait in the output register.
// Reset: rst_n clears the sequencer, divider control and m_tvalid, not the data.
// ----------------------------------------------------------------------------
module movable_feast_dates_core
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: [13:0] year, [15:14] zero
    input  logic [15:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [1:0] carnival_month, [6:2] carnival_day, [9:7] good_friday_month,
    // [14:10] good_friday_day, [17:15] paschal_month, [22:18] paschal_day,
    // [25:23] ascension_month, [30:26] ascension_day, [33:31] whitsun_month,
    // [38:34] whitsun_day, [39] zero
    output logic [39:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_MAP   = 3'd3;

    // Division steps of the computus, in order.
    localparam logic [2:0] OP_A = 3'd0;  // a = y mod 19
    localparam logic [2:0] OP_B = 3'd1;  // b = y div 100, c = y mod 100
    localparam logic [2:0] OP_F = 3'd2;  // f = (b + 8) div 25
    localparam logic [2:0] OP_G = 3'd3;  // g = (b - f + 1) div 3
    localparam logic [2:0] OP_H = 3'd4;  // h = (19a + b - d - g + 15) mod 30
    localparam logic [2:0] OP_L = 3'd5;  // l = (32 + 2e + 2i - h - k) mod 7
    localparam logic [2:0] OP_M = 3'd6;  // m = (a + 11h + 22l) div 451
    localparam logic [2:0] OP_E = 3'd7;  // month and day from h + l + 114 - 7m

    localparam int YW = mfd_pkg::YEAR_W;
    localparam int DW = mfd_pkg::DIVISOR_W;
    localparam int RW = mfd_pkg::RECIP_W;

    // Reciprocals of the divisors, rounded up.
    localparam int SCALE = 1 << mfd_pkg::RECIP_SHIFT;
    localparam logic [RW-1:0] RECIP_3   = RW'((SCALE + 3 - 1) / 3);
    localparam logic [RW-1:0] RECIP_7   = RW'((SCALE + 7 - 1) / 7);
    localparam logic [RW-1:0] RECIP_19  = RW'((SCALE + 19 - 1) / 19);
    localparam logic [RW-1:0] RECIP_25  = RW'((SCALE + 25 - 1) / 25);
    localparam logic [RW-1:0] RECIP_30  = RW'((SCALE + 30 - 1) / 30);
    localparam logic [RW-1:0] RECIP_31  = RW'((SCALE + 31 - 1) / 31);
    localparam logic [RW-1:0] RECIP_100 = RW'((SCALE + 100 - 1) / 100);
    localparam logic [RW-1:0] RECIP_451 = RW'((SCALE + 451 - 1) / 451);

    logic [2:0]             state_reg;
    logic [2:0]             op_reg;
    logic                   m_tvalid_reg;
    logic [YW-1:0]          year_reg;
    logic [4:0]             a_reg;
    logic [7:0]             b_reg;
    logic [6:0]             c_reg;
    logic [2:0]             f_reg;
    logic [5:0]             g_reg;
    logic [4:0]             h_reg;
    logic [2:0]             l_reg;
    logic                   m_reg;
    logic [2:0]             em_reg;
    logic [4:0]             ed_reg;

    logic                   div_start;
    logic [YW-1:0]          div_dividend;
    logic [DW-1:0]          div_divisor;
    logic [RW-1:0]          div_recip;
    logic                   div_done;
    logic [YW-1:0]          div_quot;
    logic [DW-1:0]          div_rem;

    logic                   out_free;
    logic                   map_load;
    logic                   leap;
    mfd_pkg::easter_t       easter;
    mfd_pkg::feast_dates_t  dates;

    assign s_tready  = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_ISSUE);
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign map_load  = (state_reg == ST_MAP) && out_free;

    // Operand and divisor for the current step, built from earlier results.
    always_comb
    begin
        div_dividend = year_reg;
        div_divisor  = DW'(19);
        div_recip    = RECIP_19;
        case (op_reg)
            OP_A:
            begin
                div_dividend = year_reg;
                div_divisor  = DW'(19);
                div_recip    = RECIP_19;
            end
            OP_B:
            begin
                div_dividend = year_reg;
                div_divisor  = DW'(100);
                div_recip    = RECIP_100;
            end
            OP_F:
            begin
                div_dividend = YW'(b_reg) + YW'(8);
                div_divisor  = DW'(25);
                div_recip    = RECIP_25;
            end
            OP_G:
            begin
                div_dividend = YW'(b_reg) - YW'(f_reg) + YW'(1);
                div_divisor  = DW'(3);
                div_recip    = RECIP_3;
            end
            OP_H:
            begin
                div_dividend = YW'(a_reg) * YW'(19) + YW'(b_reg) - YW'(b_reg[7:2])
                             - YW'(g_reg) + YW'(15);
                div_divisor  = DW'(30);
                div_recip    = RECIP_30;
            end
            OP_L:
            begin
                div_dividend = YW'(32) + YW'({b_reg[1:0], 1'b0})
                             + YW'({c_reg[6:2], 1'b0})
                             - YW'(h_reg) - YW'(c_reg[1:0]);
                div_divisor  = DW'(7);
                div_recip    = RECIP_7;
            end
            OP_M:
            begin
                div_dividend = YW'(a_reg) + YW'(h_reg) * YW'(11) + YW'(l_reg) * YW'(22);
                div_divisor  = DW'(451);
                div_recip    = RECIP_451;
            end
            OP_E:
            begin
                div_dividend = YW'(h_reg) + YW'(l_reg) + YW'(114) - (m_reg ? YW'(7) : YW'(0));
                div_divisor  = DW'(31);
                div_recip    = RECIP_31;
            end
            default:
            begin
                div_dividend = year_reg;
                div_divisor  = DW'(19);
                div_recip    = RECIP_19;
            end
        endcase
    end

    // Sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_A;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (map_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= OP_A;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        if (op_reg == OP_E)
                        begin
                            state_reg <= ST_MAP;
                        end
                        else
                        begin
                            op_reg    <= op_reg + 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_MAP:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture of the year and of each division result.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            year_reg <= s_tdata[YW-1:0];
        end
        if ((state_reg == ST_WAIT) && div_done)
        begin
            case (op_reg)
                OP_A: a_reg <= div_rem[4:0];
                OP_B:
                begin
                    b_reg <= div_quot[7:0];
                    c_reg <= div_rem[6:0];
                end
                OP_F: f_reg <= div_quot[2:0];
                OP_G: g_reg <= div_quot[5:0];
                OP_H: h_reg <= div_rem[4:0];
                OP_L: l_reg <= div_rem[2:0];
                OP_M: m_reg <= div_quot[0];
                OP_E:
                begin
                    em_reg <= div_quot[2:0];
                    ed_reg <= div_rem[4:0] + 5'd1;
                end
                default: a_reg <= a_reg;
            endcase
        end
    end

    // Leap year: divisible by 4, and by 400 when it ends a century.
    assign leap = (c_reg != 7'd0) ? (c_reg[1:0] == 2'd0) : (b_reg[1:0] == 2'd0);

    assign easter.month = em_reg;
    assign easter.day   = ed_reg;

    mfd_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .recip    (div_recip),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    mfd_dates u_dates
    (
        .clk    (clk),
        .load   (map_load),
        .leap   (leap),
        .easter (easter),
        .dates  (dates)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0,
                       dates.whitsun_day, dates.whitsun_month,
                       dates.ascension_day, dates.ascension_month,
                       dates.paschal_day, dates.paschal_month,
                       dates.good_friday_day, dates.good_friday_month,
                       dates.carnival_day, dates.carnival_month};

    // A new year is never taken while one is still being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside the wait state");

    // A result only appears after the mapping step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_MAP))
        else $error("result shown without mapping step");

    // Easter always lands in March or April.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAP) |-> ((em_reg == mfd_pkg::MONTH_MAR) ||
                                   (em_reg == mfd_pkg::MONTH_APR)))
        else $error("Easter month out of range");

endmodule
